// ----- rtl/rdg_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package rdg_pkg;

  localparam int RandBitsDefault = 16;
  localparam int CordicSteps     = 20;
  localparam int RootSteps       = 32;
  localparam logic signed [33:0] CordicGain = 34'sd652032874;
  localparam logic signed [16:0] OutMax = 17'sd65535;
  localparam logic signed [16:0] OutMin = -17'sd65536;

  typedef enum logic [1:0] {
    MODE_SPHERE = 2'd0,
    MODE_XY     = 2'd1,
    MODE_XZ     = 2'd2,
    MODE_YZ     = 2'd3
  } plane_mode_t;

  // how a component product is turned back into q8.8
  typedef enum logic [1:0] {
    AX_ZERO = 2'd0,
    AX_Q30  = 2'd1,
    AX_Q31  = 2'd2
  } axis_kind_t;

  // one slot of the rotation / square-root pipeline
  typedef struct packed {
    logic               vld;
    logic signed [32:0] ang;
    logic signed [33:0] cx;
    logic signed [33:0] cy;
    logic [1:0]         quad;
    logic [63:0]        rem;
    logic [63:0]        root;
    logic signed [31:0] z31;
    logic [15:0]        norm;
    plane_mode_t        mode;
  } rdg_stage_t;

  // arctangent of 2^-i in units of 2^-32 turn
  function automatic logic signed [32:0] atan_turn(input int idx);
    logic signed [32:0] v;
    case (idx)
      0:       v = 33'sd536870912;
      1:       v = 33'sd316933406;
      2:       v = 33'sd167458907;
      3:       v = 33'sd85004756;
      4:       v = 33'sd42667331;
      5:       v = 33'sd21354465;
      6:       v = 33'sd10679838;
      7:       v = 33'sd5340245;
      8:       v = 33'sd2670163;
      9:       v = 33'sd1335087;
      10:      v = 33'sd667544;
      11:      v = 33'sd333772;
      12:      v = 33'sd166886;
      13:      v = 33'sd83443;
      14:      v = 33'sd41722;
      15:      v = 33'sd20861;
      16:      v = 33'sd10430;
      17:      v = 33'sd5215;
      18:      v = 33'sd2608;
      19:      v = 33'sd1304;
      default: v = 33'sd0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/rdg_stage.sv -----
`timescale 1ns / 1ps
`default_nettype none

// one square-root digit per register stage, plus one cordic rotation while STEP < CordicSteps
module rdg_stage
  import rdg_pkg::*;
#(
  parameter int STEP = 0
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       adv,
  input  wire rdg_stage_t d,
  output rdg_stage_t      q
);

  localparam logic [63:0] BitV = 64'd1 << (62 - 2 * STEP);
  localparam logic signed [32:0] Atan = atan_turn(STEP);

  rdg_stage_t q_r, q_nxt;
  logic [63:0] trial;

  always_comb begin
    q_nxt = d;
    if (STEP < CordicSteps) begin
      if (!d.ang[32]) begin
        q_nxt.cx  = d.cx - (d.cy >>> STEP);
        q_nxt.cy  = d.cy + (d.cx >>> STEP);
        q_nxt.ang = d.ang - Atan;
      end else begin
        q_nxt.cx  = d.cx + (d.cy >>> STEP);
        q_nxt.cy  = d.cy - (d.cx >>> STEP);
        q_nxt.ang = d.ang + Atan;
      end
    end
    trial = d.root + BitV;
    if (d.rem >= trial) begin
      q_nxt.rem  = d.rem - trial;
      q_nxt.root = (d.root >> 1) + BitV;
    end else begin
      q_nxt.root = d.root >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r.vld <= 1'b0;
    end else if (adv) begin
      q_r <= q_nxt;
    end
  end

  assign q = q_r;

endmodule

`default_nettype wire

// ----- rtl/random_direction_generator_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none

// random direction generator: each request carries two uniform fractions
// (q0.16) and a length (q8.8) and yields one vector of that length, saturated
// q8.8 per axis. in sphere mode the angle fraction sets the longitude and the
// height fraction sets z, giving points uniform on the sphere; in the xy, xz
// and yz modes the vector lies on a circle in that plane and the height
// fraction is ignored. one request is taken every cycle unless in_stall is set.
// requests pass pipe[0], the 32-stage square-root pipeline (alongside the 20
// cordic rotations), m1, m2 and the output register. a stall on the result
// side freezes the whole pipeline, so nothing is dropped or repeated. the user
// must write plane_mode only while the unit is idle; it is not enforced.
module random_direction_generator_unit
  import rdg_pkg::*;
#(
  parameter int RAND_BITS = RandBitsDefault
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_we,
  input  wire logic [1:0]         cfg_wdata,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [15:0]        in_rand_angle,
  input  wire logic [15:0]        in_rand_height,
  input  wire logic [15:0]        in_norm,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [16:0]      out_dir_x,
  output logic signed [16:0]      out_dir_y,
  output logic signed [16:0]      out_dir_z
);

  localparam logic [63:0] RandMask = (64'd1 << RAND_BITS) - 64'd1;
  localparam logic signed [51:0] RndQ30 = 52'sd1 <<< 29;
  localparam logic signed [51:0] RndQ31 = 52'sd1 <<< 30;

  // whole pipeline moves unless the output register holds an untaken result
  logic adv;
  logic out_valid_r;
  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = !adv;

  // configuration register
  plane_mode_t plane_mode_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      plane_mode_r <= MODE_SPHERE;
    end else if (cfg_we) begin
      plane_mode_r <= plane_mode_t'(cfg_wdata);
    end
  end

  // front end: phases, quadrant fold, height and 1 - z^2
  logic [63:0] ang_bits, hgt_bits;
  logic [31:0] ph_a, ph_h;
  logic signed [31:0] z31;
  logic [63:0] zz;
  rdg_stage_t s0_nxt;
  rdg_stage_t pipe [0:RootSteps];

  always_comb begin
    ang_bits = ({48'd0, in_rand_angle} & RandMask) << (32 - RAND_BITS);
    hgt_bits = ({48'd0, in_rand_height} & RandMask) << (32 - RAND_BITS);
    ph_a     = ang_bits[31:0];
    ph_h     = hgt_bits[31:0];
    // z in q1.31 is the phase with its top bit flipped
    z31      = signed'({~ph_h[31], ph_h[30:0]});
    zz       = 64'(z31 * z31);
    s0_nxt.vld  = in_valid;
    // centre the remainder to +-45 deg, moving the quadrant up when folded
    s0_nxt.ang  = 33'(signed'(ph_a[29:0]));
    s0_nxt.quad = ph_a[31:30] + {1'b0, ph_a[29]};
    s0_nxt.cx   = CordicGain;
    s0_nxt.cy   = '0;
    s0_nxt.rem  = (64'd1 << 62) - zz;
    s0_nxt.root = '0;
    s0_nxt.z31  = z31;
    s0_nxt.norm = in_norm;
    s0_nxt.mode = plane_mode_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pipe[0].vld <= 1'b0;
    end else if (adv) begin
      pipe[0] <= s0_nxt;
    end
  end

  for (genvar k = 0; k < RootSteps; k++) begin : g_stage
    rdg_stage #(.STEP(k)) u_stage (
      .clk   (clk),
      .rst_n (rst_n),
      .adv   (adv),
      .d     (pipe[k]),
      .q     (pipe[k+1])
    );
  end

  // quadrant rotation and products with sqrt(1 - z^2)
  rdg_stage_t         fin;
  logic signed [33:0] c_q, s_q;
  logic signed [32:0] st;
  logic               m1_vld_r;
  logic signed [33:0] m1_c_r, m1_s_r;
  logic signed [66:0] m1_pc_r, m1_ps_r;
  logic signed [31:0] m1_z31_r;
  logic [15:0]        m1_norm_r;
  plane_mode_t        m1_mode_r;

  assign fin = pipe[RootSteps];
  assign st  = signed'({1'b0, fin.root[31:0]});

  always_comb begin
    case (fin.quad)
      2'd0:    begin c_q = fin.cx;  s_q = fin.cy;  end
      2'd1:    begin c_q = -fin.cy; s_q = fin.cx;  end
      2'd2:    begin c_q = -fin.cx; s_q = -fin.cy; end
      default: begin c_q = fin.cy;  s_q = -fin.cx; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m1_vld_r <= 1'b0;
    end else if (adv) begin
      m1_vld_r <= fin.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m1_c_r    <= c_q;
      m1_s_r    <= s_q;
      m1_pc_r   <= c_q * st;
      m1_ps_r   <= s_q * st;
      m1_z31_r  <= fin.z31;
      m1_norm_r <= fin.norm;
      m1_mode_r <= fin.mode;
    end
  end

  // route to axes and scale by the length
  logic signed [33:0] vc, vs, vx, vy, vz;
  logic signed [31:0] zsel;
  axis_kind_t         kx, ky, kz;
  logic signed [16:0] n_s;
  logic               m2_vld_r;
  logic signed [51:0] m2_px_r, m2_py_r, m2_pz_r;
  axis_kind_t         m2_kx_r, m2_ky_r, m2_kz_r;

  always_comb begin
    n_s = signed'({1'b0, m1_norm_r});
    if (m1_mode_r == MODE_SPHERE) begin
      vc = 34'(m1_pc_r >>> 31);
      vs = 34'(m1_ps_r >>> 31);
    end else begin
      vc = m1_c_r;
      vs = m1_s_r;
    end
    zsel = m1_z31_r;
    vx = vc; vy = vs; vz = '0;
    kx = AX_Q30; ky = AX_Q30; kz = AX_ZERO;
    unique case (m1_mode_r)
      MODE_SPHERE: begin
        vz = 34'(zsel);
        kz = AX_Q31;
      end
      MODE_XY: begin
        kz = AX_ZERO;
      end
      MODE_XZ: begin
        vy = '0; ky = AX_ZERO;
        vz = vs; kz = AX_Q30;
      end
      default: begin
        vx = '0; kx = AX_ZERO;
        vy = vc; vz = vs; kz = AX_Q30;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m2_vld_r <= 1'b0;
    end else if (adv) begin
      m2_vld_r <= m1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m2_px_r <= 52'(n_s * vx);
      m2_py_r <= 52'(n_s * vy);
      m2_pz_r <= 52'(n_s * vz);
      m2_kx_r <= kx;
      m2_ky_r <= ky;
      m2_kz_r <= kz;
    end
  end

  // round half up, saturate, output register
  function automatic logic signed [16:0] fin_axis(input logic signed [51:0] p,
                                                   input axis_kind_t k);
    logic signed [51:0] r;
    logic signed [16:0] o;
    if (k == AX_Q31) begin
      r = (p + RndQ31) >>> 31;
    end else begin
      r = (p + RndQ30) >>> 30;
    end
    if (k == AX_ZERO) begin
      o = '0;
    end else if (r > 52'(OutMax)) begin
      o = OutMax;
    end else if (r < 52'(OutMin)) begin
      o = OutMin;
    end else begin
      o = r[16:0];
    end
    return o;
  endfunction

  logic signed [16:0] out_x_r, out_y_r, out_z_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= m2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_x_r <= fin_axis(m2_px_r, m2_kx_r);
      out_y_r <= fin_axis(m2_py_r, m2_ky_r);
      out_z_r <= fin_axis(m2_pz_r, m2_kz_r);
    end
  end

  assign out_valid = out_valid_r;
  assign out_dir_x = out_x_r;
  assign out_dir_y = out_y_r;
  assign out_dir_z = out_z_r;

endmodule

`default_nettype wire
